/* rtl/core/lcdbr_pkg.sv */
// Package with the codes, constants and init sequence table of the character-LCD front end.
`default_nettype none

package lcdbr_pkg;

    // Default geometry of the text buffer.
    localparam int ROWS_DEF = 2;
    localparam int COLS_DEF = 16;

    // Field widths of the input and result words.
    localparam int OP_W     = 3;
    localparam int COLUMN_W = 5;
    localparam int CHAR_W   = 8;
    localparam int SPAN_W   = 5;
    localparam int NIBBLE_W = 4;

    // Packed widths on the stream ports.
    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 8;
    localparam int OUT_TUSER_W = 2;

    // Character and command codes.
    localparam logic [7:0] SPACE_CODE = 8'h20;
    localparam logic [7:0] CURSOR_CMD = 8'h80;
    localparam logic [7:0] ROW_OFFSET = 8'h40;

    // Init sequence: 4 wake-up nibbles, 6 command bytes, 16 glyph bytes.
    localparam int WAKE_NIBBLES = 4;
    localparam int SETUP_BYTES  = 6;
    localparam int GLYPH_BYTES  = 16;
    localparam int INIT_NIBBLES = WAKE_NIBBLES + 2 * SETUP_BYTES + 2 * GLYPH_BYTES;
    localparam int INIT_IDX_W   = $clog2(INIT_NIBBLES);

    localparam logic [3:0] WAKE_NIB  = 4'h3;
    localparam logic [3:0] WAKE_LAST = 4'h2;

    localparam logic [7:0] SETUP_CMDS [SETUP_BYTES] = '{
        8'h28, 8'h08, 8'h01, 8'h06, 8'h0C, 8'h40
    };

    // Up-arrow glyph followed by down-arrow glyph.
    localparam logic [7:0] GLYPH_ROWS [GLYPH_BYTES] = '{
        8'h04, 8'h0E, 8'h15, 8'h04, 8'h04, 8'h04, 8'h04, 8'h04,
        8'h04, 8'h04, 8'h04, 8'h04, 8'h04, 8'h15, 8'h0E, 8'h04
    };

    // Operation codes.
    typedef enum logic [OP_W-1:0] {
        OP_INIT      = 3'd0,
        OP_PUT       = 3'd1,
        OP_CLR_SPAN  = 3'd2,
        OP_CLR_ALL   = 3'd3,
        OP_REFRESH   = 3'd4
    } t_op;

    // Sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_INIT,
        ST_REFRESH
    } t_state;

    // One nibble headed for the display.
    typedef struct packed {
        logic [NIBBLE_W-1:0] nibble;
        logic                rs;
        logic                wait_busy;
    } t_nib;

    // Nibble number idx of the init sequence.
    function automatic t_nib init_nibble(input logic [INIT_IDX_W-1:0] idx);
        t_nib                  res;
        logic [INIT_IDX_W-1:0] j;
        logic [7:0]            b;
        res = '0;
        j   = '0;
        b   = '0;
        if (idx < INIT_IDX_W'(WAKE_NIBBLES)) begin
            res.nibble    = (idx == INIT_IDX_W'(WAKE_NIBBLES - 1)) ? WAKE_LAST : WAKE_NIB;
            res.rs        = 1'b0;
            res.wait_busy = 1'b0;
        end else if (idx < INIT_IDX_W'(WAKE_NIBBLES + 2 * SETUP_BYTES)) begin
            j             = idx - INIT_IDX_W'(WAKE_NIBBLES);
            b             = SETUP_CMDS[j[3:1]];
            res.nibble    = j[0] ? b[3:0] : b[7:4];
            res.rs        = 1'b0;
            res.wait_busy = j[0];
        end else begin
            j             = idx - INIT_IDX_W'(WAKE_NIBBLES + 2 * SETUP_BYTES);
            b             = GLYPH_ROWS[j[4:1]];
            res.nibble    = j[0] ? b[3:0] : b[7:4];
            res.rs        = 1'b1;
            res.wait_busy = j[0];
        end
        return res;
    endfunction

endpackage

`default_nettype wire

/* rtl/core/char_lcd_buffer_refresh_top.sv */
// Character-LCD front end: text buffer memory, init and row refresh nibble sequencer.
//
// Usage: operation words enter on the s_axis channel, one operation per word.
// Put char, clear span and clear all only change the text buffer;
// they start no run. Init clears the buffer and sends 48 nibbles (wake-up, set-up
// commands, two custom glyphs). Refresh row sends the cursor command and the
// row's COLS characters, 2 + 2*COLS nibbles. Every nibble leaves on the m_axis
// channel with register select and busy-wait flags in tuser; tlast marks the
// final nibble of a run. Out-of-range writes and refreshes are dropped.
// Throughput: one nibble per cycle while the receiver is ready; the rate is
// set by the one-nibble output register and the single read port of the
// buffer, which is read one cell ahead.
// s_axis_tready is high only while no run is in progress.
// Reset clears the buffer to spaces at once (a valid bit per cell) and drops
// any run in progress. When the receiver stalls, the output word holds and the
// sequencer waits; nothing is lost.
`default_nettype none

module char_lcd_buffer_refresh_top #(
    parameter int ROWS = lcdbr_pkg::ROWS_DEF,
    parameter int COLS = lcdbr_pkg::COLS_DEF
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    // Input words.
    input  wire logic                               s_axis_tvalid,
    output logic                                    s_axis_tready,
    // tdata: op[2:0], row[3], column[8:4], char_code[16:9], span_length[21:17], zeros
    input  wire logic [lcdbr_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
    // Result words.
    output logic                                    m_axis_tvalid,
    input  wire logic                               m_axis_tready,
    // tdata: nibble[3:0], zeros
    output logic [lcdbr_pkg::OUT_TDATA_W-1:0]       m_axis_tdata,
    // tuser: register_select[0], wait_busy[1]
    output logic [lcdbr_pkg::OUT_TUSER_W-1:0]       m_axis_tuser,
    output logic                                    m_axis_tlast
);
    import lcdbr_pkg::*;

    localparam int DEPTH = ROWS * COLS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNTW  = $clog2(COLS + 1);

    // Unpacked input fields.
    logic [OP_W-1:0]     w_op;
    logic                w_row;
    logic [COLUMN_W-1:0] w_column;
    logic [CHAR_W-1:0]   w_char;
    logic [SPAN_W-1:0]   w_span;

    assign w_op     = s_axis_tdata[2:0];
    assign w_row    = s_axis_tdata[3];
    assign w_column = s_axis_tdata[8:4];
    assign w_char   = s_axis_tdata[16:9];
    assign w_span   = s_axis_tdata[21:17];

    // Sequencer and buffer state.
    t_state                r_state, n_state;
    logic [INIT_IDX_W-1:0] r_init_idx;
    logic [CNTW-1:0]       r_cnt;
    logic                  r_phase;
    logic                  r_row;
    logic [CHAR_W-1:0]     r_mem [DEPTH];
    logic [DEPTH-1:0]      r_valid;
    logic [CHAR_W-1:0]     r_rd_data;
    logic                  r_rd_valid;

    // Output register.
    logic                r_out_valid;
    t_nib                r_out;
    logic                r_out_last;

    logic                w_accept;
    logic                w_row_ok;
    logic                w_col_ok;
    logic [AW-1:0]       w_put_addr;
    logic [5:0]          w_span_end;
    logic [DEPTH-1:0]    w_span_clr;
    logic                w_adv;
    t_nib                w_nib;
    logic                w_last;
    logic                w_rd_en;
    logic [AW-1:0]       w_rd_addr;
    logic [7:0]          w_byte;
    logic [7:0]          w_cell;

    assign w_accept   = s_axis_tvalid && s_axis_tready;
    assign w_row_ok   = int'(w_row) < ROWS;
    assign w_col_ok   = int'(w_column) < COLS;
    assign w_put_addr = AW'(int'(w_row) * COLS + int'(w_column));
    assign w_span_end = {1'b0, w_column} + {1'b0, w_span};
    assign w_adv      = (r_state != ST_IDLE) && (!r_out_valid || m_axis_tready);

    assign s_axis_tready = (r_state == ST_IDLE);

    // Cells of the addressed row that a clear span turns back to spaces.
    always_comb begin
        w_span_clr = '0;
        for (int rr = 0; rr < ROWS; rr++) begin
            for (int cc = 0; cc < COLS; cc++) begin
                if ((int'(w_row) == rr) && (6'(cc) >= {1'b0, w_column})
                        && (6'(cc) < w_span_end)) begin
                    w_span_clr[rr * COLS + cc] = 1'b1;
                end
            end
        end
    end

    // Next state of the sequencer.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept && (w_op == OP_INIT)) begin
                    n_state = ST_INIT;
                end else if (w_accept && (w_op == OP_REFRESH) && w_row_ok) begin
                    n_state = ST_REFRESH;
                end
            end
            ST_INIT, ST_REFRESH: begin
                if (w_adv && w_last) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Sequencer outputs: the next nibble and the buffer read one cell ahead.
    always_comb begin
        w_cell    = r_rd_valid ? r_rd_data : SPACE_CODE;
        w_byte    = (r_cnt == '0) ? (CURSOR_CMD | (r_row ? ROW_OFFSET : 8'h00)) : w_cell;
        w_nib     = '0;
        w_last    = 1'b0;
        w_rd_en   = 1'b0;
        w_rd_addr = AW'(int'(r_row) * COLS + int'(r_cnt));
        unique case (r_state)
            ST_IDLE: begin
                w_nib  = '0;
                w_last = 1'b0;
            end
            ST_INIT: begin
                w_nib  = init_nibble(r_init_idx);
                w_last = (r_init_idx == INIT_IDX_W'(INIT_NIBBLES - 1));
            end
            ST_REFRESH: begin
                w_nib.nibble    = r_phase ? w_byte[3:0] : w_byte[7:4];
                w_nib.rs        = (r_cnt != '0);
                w_nib.wait_busy = r_phase;
                w_last          = (r_cnt == CNTW'(COLS)) && r_phase;
                w_rd_en         = w_adv && r_phase && (int'(r_cnt) < COLS);
            end
            default: begin
                w_nib  = '0;
                w_last = 1'b0;
            end
        endcase
    end

    // Control registers: state, run counters, valid bits and output valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_init_idx  <= '0;
            r_cnt       <= '0;
            r_phase     <= 1'b0;
            r_valid     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_accept) begin
                r_init_idx <= '0;
                r_cnt      <= '0;
                r_phase    <= 1'b0;
                if ((w_op == OP_INIT) || (w_op == OP_CLR_ALL)) begin
                    r_valid <= '0;
                end else if ((w_op == OP_PUT) && w_row_ok && w_col_ok) begin
                    r_valid[w_put_addr] <= 1'b1;
                end else if ((w_op == OP_CLR_SPAN) && w_row_ok && w_col_ok) begin
                    r_valid <= r_valid & ~w_span_clr;
                end
            end else if (w_adv) begin
                r_init_idx <= r_init_idx + 1'b1;
                r_phase    <= ~r_phase;
                if (r_phase) begin
                    r_cnt <= r_cnt + 1'b1;
                end
            end
            if (w_adv) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Run row and output payload registers.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_row <= w_row;
        end
        if (w_adv) begin
            r_out      <= w_nib;
            r_out_last <= w_last;
        end
    end

    // Text buffer memory: one write port for put, one registered read port.
    always_ff @(posedge i_clk) begin
        if (w_accept && (w_op == OP_PUT) && w_row_ok && w_col_ok) begin
            r_mem[w_put_addr] <= w_char;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rd_en) begin
            r_rd_data  <= r_mem[w_rd_addr];
            r_rd_valid <= r_valid[w_rd_addr];
        end
    end

    // Result word packing.
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(OUT_TDATA_W - NIBBLE_W){1'b0}}, r_out.nibble};
    assign m_axis_tuser  = {r_out.wait_busy, r_out.rs};
    assign m_axis_tlast  = r_out_last;

endmodule

`default_nettype wire
